### sv/tplcm_pkg.sv
// Package: phrase ROM, LED actions and the item record passed along the cell chain.
`default_nettype none
package tplcm_pkg;

	localparam int NUM_PHRASES    = 6;
	localparam int MAX_PHRASE_LEN = 18;
	localparam int ROM_ROWS       = 16;
	localparam int ROM_COLS       = 32;
	localparam int CH_W           = 8;
	localparam int POS_W          = $clog2(ROM_COLS);
	localparam int LED_W          = 3;
	localparam int MATCH_W        = 6;

	localparam logic [LED_W-1:0] LED_NONE = 3'h0;
	localparam logic [LED_W-1:0] LED_NUM  = 3'h2;
	localparam logic [LED_W-1:0] LED_CAPS = 3'h4;
	localparam logic [LED_W-1:0] LED_ALL  = 3'h7;

	typedef logic [CH_W-1:0] char_t;
	typedef logic [ROM_COLS-1:0][CH_W-1:0] row_t;

	typedef struct packed {
		row_t              row;
		logic [POS_W-1:0]  len;
		logic [LED_W-1:0]  act_set;
		logic [LED_W-1:0]  act_clr;
	} phrase_t;

	// LED effect so far is leds' = (leds & keep_mask) | set_mask
	typedef struct packed {
		char_t                  ch;
		logic                   last;
		logic [LED_W-1:0]       keep_mask;
		logic [LED_W-1:0]       set_mask;
		logic [NUM_PHRASES-1:0] hits;
	} item_t;

	function automatic phrase_t phrase_get(input int idx);
		phrase_t                   p;
		logic [ROM_COLS*CH_W-1:0]  lit;
		int                        n_raw;
		int                        n;
		lit     = '0;
		n_raw   = 0;
		p.act_set = LED_NONE;
		p.act_clr = LED_NONE;
		case (idx)
			0: begin
				lit = "start caps";          n_raw = 10; p.act_set = LED_CAPS;
			end
			1: begin
				lit = "stop caps";           n_raw = 9;  p.act_clr = LED_CAPS;
			end
			2: begin
				lit = "start num";           n_raw = 9;  p.act_set = LED_NUM;
			end
			3: begin
				lit = "stop num";            n_raw = 8;  p.act_clr = LED_NUM;
			end
			4: begin
				lit = "let there be light";  n_raw = 18; p.act_set = LED_ALL;
			end
			5: begin
				lit = "lights out";          n_raw = 10; p.act_clr = LED_ALL;
			end
			default: begin
				lit = '0;                    n_raw = 0;
			end
		endcase
		for (int j = 0; j < ROM_COLS; j++) begin
			if (j < n_raw)
				p.row[j] = lit[(n_raw-1-j)*CH_W +: CH_W];
			else
				p.row[j] = '0;
		end
		n = n_raw;
		if (n > MAX_PHRASE_LEN)
			n = MAX_PHRASE_LEN;
		if (n > ROM_COLS - 1)
			n = ROM_COLS - 1;
		p.len = POS_W'(n);
		return p;
	endfunction

endpackage
`default_nettype wire

### sv/typed_phrase_led_command_matcher.sv
// Top level: chain of phrase cells feeding the LED state and result register.
// Result path: the last character of a key passes through every phrase cell stage, then the result register.
// Throughput: one character per cycle; the chain only halts while a result waits under stall.
// Each phrase cell is one pipeline stage; the LED register updates once per key at the end.
// Reset: asynchronous, clears all match positions, skip flags, LEDs and valid bits.
`default_nettype none
module typed_phrase_led_command_matcher (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            key_valid,
	output logic                           key_stall,
	input  wire  [tplcm_pkg::CH_W-1:0]     ch,
	input  wire                            last_of_key,
	output logic                           res_valid,
	input  wire                            res_stall,
	output logic [tplcm_pkg::LED_W-1:0]    led_bits,
	output logic [tplcm_pkg::MATCH_W-1:0]  matched
);
	import tplcm_pkg::*;

	logic                     advance;
	logic [NUM_PHRASES:0]     vld;
	item_t                    itm [NUM_PHRASES+1];
	item_t                    tail;

	logic                     res_valid_q;
	logic [LED_W-1:0]         leds_q;
	logic [MATCH_W-1:0]       matched_q;
	logic [LED_W-1:0]         leds_n;
	logic [MATCH_W-1:0]       matched_n;

	assign advance   = !(res_valid_q && res_stall);
	assign key_stall = !advance;

	always_comb begin
		itm[0].ch        = ch;
		itm[0].last      = last_of_key;
		itm[0].keep_mask = '1;
		itm[0].set_mask  = '0;
		itm[0].hits      = '0;
	end
	assign vld[0] = key_valid;

	for (genvar g = 0; g < NUM_PHRASES; g++) begin : g_cell
		tplcm_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.advance   (advance),
			.in_valid  (vld[g]),
			.in_item   (itm[g]),
			.phrase    (phrase_get(g)),
			.out_valid (vld[g+1]),
			.out_item  (itm[g+1])
		);
	end

	assign tail = itm[NUM_PHRASES];

	always_comb begin
		leds_n    = (leds_q & tail.keep_mask) | tail.set_mask;
		matched_n = '0;
		for (int j = 0; j < MATCH_W; j++) begin
			if (j < NUM_PHRASES)
				matched_n[j] = tail.hits[j];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			leds_q      <= '0;
		end else if (advance) begin
			res_valid_q <= vld[NUM_PHRASES] && tail.last;
			if (vld[NUM_PHRASES] && tail.last)
				leds_q <= leds_n;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && vld[NUM_PHRASES] && tail.last)
			matched_q <= matched_n;
	end

	assign res_valid = res_valid_q;
	assign led_bits  = leds_q;
	assign matched   = matched_q;

	a_stall_only_on_held_result: assert property (@(posedge clk) disable iff (!arst_n)
		key_stall |-> (res_valid && res_stall))
		else $error("request stalled without a held result");

	a_key_end_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && vld[NUM_PHRASES] && tail.last) |=> res_valid)
		else $error("end of key produced no result");

	a_mid_key_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !(vld[NUM_PHRASES] && tail.last)) |=> !res_valid)
		else $error("result without end of key");

	a_leds_hold_without_result: assert property (@(posedge clk) disable iff (!arst_n)
		!(advance && vld[NUM_PHRASES] && tail.last) |=> $stable(leds_q))
		else $error("LED state changed outside end of key");

endmodule
`default_nettype wire

### sv/tplcm_cell.sv
// One matcher cell: match state of a single phrase plus one pipeline stage of the request.
`default_nettype none
module tplcm_cell (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 advance,
	input  wire                 in_valid,
	input  tplcm_pkg::item_t    in_item,
	input  tplcm_pkg::phrase_t  phrase,
	output logic                out_valid,
	output tplcm_pkg::item_t    out_item
);
	import tplcm_pkg::*;

	logic [POS_W-1:0]     pos_q;
	logic                 skip_q;
	logic                 vld_s1;
	item_t                item_s1;

	logic [POS_W-1:0]     pos_n;
	logic                 skip_n;
	logic                 hit;
	logic                 done;
	logic [NUM_PHRASES:0] hits_ext;
	item_t                nxt;

	always_comb begin
		pos_n  = pos_q;
		skip_n = skip_q;
		hit    = (pos_q < phrase.len) && (phrase.row[pos_q] == in_item.ch);
		if (!skip_q) begin
			if (hit) begin
				pos_n = pos_q + POS_W'(1);
			end else begin
				pos_n  = ((phrase.len != '0) && (phrase.row[0] == in_item.ch)) ?
					POS_W'(1) : '0;
				skip_n = 1'b1;
			end
		end
		done = in_item.last && (phrase.len != '0) && (pos_n == phrase.len);
		if (in_item.last)
			skip_n = 1'b0;

		nxt = in_item;
		if (done) begin
			nxt.keep_mask = in_item.keep_mask & ~phrase.act_set & ~phrase.act_clr;
			nxt.set_mask  = (in_item.set_mask | phrase.act_set) & ~phrase.act_clr;
		end
		hits_ext = {done, in_item.hits};
		nxt.hits = hits_ext[NUM_PHRASES:1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			skip_q <= 1'b0;
			vld_s1 <= 1'b0;
		end else if (advance) begin
			vld_s1 <= in_valid;
			if (in_valid) begin
				pos_q  <= pos_n;
				skip_q <= skip_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && in_valid)
			item_s1 <= nxt;
	end

	assign out_valid = vld_s1;
	assign out_item  = item_s1;

endmodule
`default_nettype wire

### dv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the typed-phrase LED command matcher.
module tb_top;
	import tplcm_pkg::*;

	localparam int IDLE_LIMIT = 3000;
	localparam int RANDOM_CHARS = 1750;

	class led_phrase_scoreboard;
		string             phrase_text [NUM_PHRASES];
		logic [LED_W-1:0]  led_on [NUM_PHRASES];
		logic [LED_W-1:0]  led_off [NUM_PHRASES];
		logic [POS_W-1:0]  pos [NUM_PHRASES];
		logic              skip [NUM_PHRASES];
		logic [LED_W-1:0]  leds;
		logic [LED_W-1:0]  pending_leds [$];
		logic [MATCH_W-1:0] pending_hits [$];
		int unsigned       done_cnt [NUM_PHRASES];
		int unsigned       num_checked;
		int unsigned       errors;

		function new();
			phrase_text[0] = "start caps";
			phrase_text[1] = "stop caps";
			phrase_text[2] = "start num";
			phrase_text[3] = "stop num";
			phrase_text[4] = "let there be light";
			phrase_text[5] = "lights out";
			led_on[0] = LED_CAPS; led_off[0] = LED_NONE;
			led_on[1] = LED_NONE; led_off[1] = LED_CAPS;
			led_on[2] = LED_NUM;  led_off[2] = LED_NONE;
			led_on[3] = LED_NONE; led_off[3] = LED_NUM;
			led_on[4] = LED_ALL;  led_off[4] = LED_NONE;
			led_on[5] = LED_NONE; led_off[5] = LED_ALL;
			for (int i = 0; i < NUM_PHRASES; i++) begin
				pos[i] = '0;
				skip[i] = 1'b0;
				done_cnt[i] = 0;
			end
			leds = LED_NONE;
			num_checked = 0;
			errors = 0;
		endfunction

		function int pending();
			return pending_leds.size();
		endfunction

		// Advance every phrase on one accepted character request.
		function void note_char(input logic [CH_W-1:0] c, input logic is_last);
			logic [MATCH_W-1:0] hits;
			logic [CH_W-1:0]    rom_ch;
			int                 len;
			int                 p;
			hits = '0;
			for (int i = 0; i < NUM_PHRASES; i++) begin
				len = phrase_text[i].len();
				if (len > MAX_PHRASE_LEN)
					len = MAX_PHRASE_LEN;
				p = int'(pos[i]);
				if (!skip[i]) begin
					rom_ch = (p < len) ? phrase_text[i][p] : '0;
					if (p < len && rom_ch == c) begin
						p++;
					end else begin
						rom_ch = phrase_text[i][0];
						p = (len > 0 && rom_ch == c) ? 1 : 0;
						skip[i] = 1'b1;
					end
					pos[i] = POS_W'(p);
				end
				if (is_last) begin
					if (len > 0 && p == len) begin
						hits[i] = 1'b1;
						leds = (leds | led_on[i]) & ~led_off[i];
						done_cnt[i]++;
					end
					skip[i] = 1'b0;
				end
			end
			if (is_last) begin
				pending_leds.push_back(leds);
				pending_hits.push_back(hits);
			end
		endfunction

		task report(input string msg);
			errors++;
			if (errors <= 40)
				$display("%0t ns mismatch: %s", $time, msg);
		endtask

		task check_leds(input logic [LED_W-1:0] got_leds, input logic [MATCH_W-1:0] got_hits);
			logic [LED_W-1:0]   want_leds;
			logic [MATCH_W-1:0] want_hits;
			num_checked++;
			if (pending_leds.size() == 0) begin
				report($sformatf("unexpected result led_bits=%0h matched=%0h",
					got_leds, got_hits));
			end else begin
				want_leds = pending_leds.pop_front();
				want_hits = pending_hits.pop_front();
				if (got_leds !== want_leds)
					report($sformatf("result %0d led_bits %0h, expected %0h",
						num_checked, got_leds, want_leds));
				if (got_hits !== want_hits)
					report($sformatf("result %0d matched %0h, expected %0h",
						num_checked, got_hits, want_hits));
			end
		endtask
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               key_valid = 1'b0;
	logic               key_stall;
	logic [CH_W-1:0]    ch = '0;
	logic               last_of_key = 1'b0;
	logic               res_valid;
	logic               res_stall = 1'b0;
	logic [LED_W-1:0]   led_bits;
	logic [MATCH_W-1:0] matched;

	led_phrase_scoreboard sb = new();
	bit          steady = 1'b0;
	int unsigned chars_sent = 0;
	int unsigned quiet_cycles = 0;

	typed_phrase_led_command_matcher uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.key_valid  (key_valid),
		.key_stall  (key_stall),
		.ch         (ch),
		.last_of_key(last_of_key),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.led_bits   (led_bits),
		.matched    (matched)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	task automatic send_char(input logic [CH_W-1:0] c, input logic is_last);
		if (!steady && $urandom_range(99) < 35) begin
			key_valid <= 1'b0;
			repeat ($urandom_range(3, 1)) @(posedge clk);
		end
		key_valid <= 1'b1;
		ch <= c;
		last_of_key <= is_last;
		do @(posedge clk); while (key_stall);
		sb.note_char(c, is_last);
		chars_sent++;
	endtask

	task automatic type_key(input string s);
		for (int j = 0; j < s.len(); j++)
			send_char(s[j], j == s.len() - 1);
	endtask

	// Each character its own key, or now and then a few run together in one key.
	task automatic type_text(input string s, input bit grouped);
		int i;
		int n;
		i = 0;
		while (i < s.len()) begin
			n = (grouped && $urandom_range(3) == 0) ? $urandom_range(3, 2) : 1;
			if (i + n > s.len())
				n = s.len() - i;
			for (int j = 0; j < n; j++)
				send_char(s[i+j], j == n - 1);
			i += n;
		end
	endtask

	task automatic wait_results_drained();
		key_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	// Result side: random stall, with two long hold-offs so the chain backs up.
	initial begin : result_side
		int hold_left;
		hold_left = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (res_valid && !res_stall) begin
				sb.check_leds(led_bits, matched);
				if (sb.num_checked == 40 || sb.num_checked == 400)
					hold_left = 300;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_stall <= 1'b1;
			end else begin
				res_stall <= !steady && ($urandom_range(99) < 35);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((key_valid && !key_stall) || (res_valid && !res_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= IDLE_LIMIT) begin
				$display("watchdog: no request moved for %0d cycles", IDLE_LIMIT);
				$display("typed_phrase_led_command_matcher regression: fail");
				$finish;
			end
		end
	end

	initial begin : stimulus
		string       s;
		int          sel;
		int          ph;
		int          n;
		bit          paused;
		paused = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		type_text("stop num", 1'b0);
		type_key("x");                  // phrase complete: next char restarts it
		type_key("st");
		send_char(8'h00, 1'b0);         // zero char never matches
		send_char(8'hff, 1'b0);
		send_char(8'h01, 1'b1);
		type_key("ks");                 // mismatch ignores rest of key
		type_text("stop nu", 1'b0);
		type_key("mx");                 // completes, then lost before end of key
		wait_results_drained();

		while (chars_sent < RANDOM_CHARS) begin
			steady = (chars_sent >= 700 && chars_sent < 1000);
			sel = $urandom_range(99);
			ph = $urandom_range(NUM_PHRASES - 1);
			s = sb.phrase_text[ph];
			if (sel < 55) begin
				type_text(s, 1'b1);
			end else if (sel < 72) begin
				n = $urandom_range(s.len() - 1);
				s[n] = CH_W'($urandom_range(255, 1));
				if ($urandom_range(1))
					s = s.substr(0, n);
				type_text(s, 1'b1);
			end else begin
				n = $urandom_range(4, 1);
				for (int j = 0; j < n; j++)
					send_char(CH_W'($urandom_range(255, 1)), j == n - 1);
			end
			if (!paused && chars_sent >= 1300) begin
				paused = 1'b1;
				wait_results_drained();
			end
		end
		steady = 1'b0;
		wait_results_drained();
		repeat (20) @(posedge clk);

		$display("sent %0d character requests, checked %0d result requests, %0d errors",
			chars_sent, sb.num_checked, sb.errors);
		$display("phrase completions: %0d %0d %0d %0d %0d %0d",
			sb.done_cnt[0], sb.done_cnt[1], sb.done_cnt[2],
			sb.done_cnt[3], sb.done_cnt[4], sb.done_cnt[5]);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("typed_phrase_led_command_matcher regression: pass");
		else
			$display("typed_phrase_led_command_matcher regression: fail");
		$finish;
	end

endmodule
